>>> rtl/ccks_pkg.sv
// shared types, constants and helper functions for the chacha keystream byte generator
// no dependencies; imported by every module of the block
package ccks_pkg;

	localparam int DOUBLE_ROUNDS = 10;
	localparam int MAX_REQUEST   = 64;

	localparam int LANES       = 4;
	localparam int WORDS       = 16;
	localparam int BLOCK_BYTES = 64;
	localparam int STEPS       = DOUBLE_ROUNDS * 8;
	localparam int STEP_W      = $clog2(STEPS);
	localparam int REQ_W       = $clog2(MAX_REQUEST + 1);
	localparam int POS_W       = 7;

	localparam logic [31:0] SIGMA0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

	// quarter-round operand roles
	localparam logic [1:0] ROLE_A = 2'd0;
	localparam logic [1:0] ROLE_B = 2'd1;
	localparam logic [1:0] ROLE_C = 2'd2;
	localparam logic [1:0] ROLE_D = 2'd3;

	typedef logic [31:0] word_t;
	typedef logic [WORDS-1:0][31:0] blk_t;
	typedef logic [LANES-1:0][31:0] lanes_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_SERVE,
		TOP_GEN
	} top_state_t;

	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_ROUND,
		CORE_FINAL
	} core_state_t;

	typedef struct packed {
		logic start;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	// block input words from seed and block counter
	function automatic blk_t init_block(input logic [63:0] seed, input logic [63:0] ctr);
		blk_t  b;
		word_t lo;
		word_t hi;
		lo = seed[31:0];
		hi = seed[63:32];
		b[0]  = SIGMA0;
		b[1]  = SIGMA1;
		b[2]  = SIGMA2;
		b[3]  = SIGMA3;
		b[4]  = lo;
		b[5]  = hi;
		b[6]  = lo;
		b[7]  = hi;
		b[8]  = ~lo;
		b[9]  = ~hi;
		b[10] = lo;
		b[11] = hi;
		b[12] = ctr[31:0];
		b[13] = ctr[63:32];
		b[14] = '0;
		b[15] = '0;
		return b;
	endfunction

	// word index of one operand of a lane, column or diagonal round
	function automatic logic [3:0] lane_idx(input int lane, input logic diag,
			input logic [1:0] role);
		int r;
		int col;
		r   = int'(role);
		col = diag ? (lane + r) % 4 : lane;
		return 4'(r * 4 + col);
	endfunction

	// saturate a request to the largest run length
	function automatic logic [REQ_W-1:0] sat_count(input logic [6:0] cnt);
		int n;
		n = int'(cnt);
		if (n > MAX_REQUEST) begin
			n = MAX_REQUEST;
		end
		return REQ_W'(n);
	endfunction

endpackage

>>> rtl/ccks_arx.sv
// shared add-xor-rotate unit: four lanes, one quarter-round line per cycle
// depends on ccks_pkg
module ccks_arx
	import ccks_pkg::*;
(
	input  lanes_t     x,
	input  lanes_t     y,
	input  lanes_t     z,
	input  logic [1:0] line,
	output lanes_t     x_nxt,
	output lanes_t     z_nxt
);

	lanes_t sum;
	lanes_t mix;

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			sum[j] = x[j] + y[j];
			mix[j] = z[j] ^ sum[j];
			unique case (line)
				2'd0: z_nxt[j] = {mix[j][15:0], mix[j][31:16]};
				2'd1: z_nxt[j] = {mix[j][19:0], mix[j][31:20]};
				2'd2: z_nxt[j] = {mix[j][23:0], mix[j][31:24]};
				2'd3: z_nxt[j] = {mix[j][24:0], mix[j][31:25]};
				default: z_nxt[j] = mix[j];
			endcase
		end
		x_nxt = sum;
	end

endmodule

>>> rtl/ccks_core.sv
// block function sequencer: seed, block counter, round words, keystream words
// depends on ccks_pkg and ccks_arx
module ccks_core
	import ccks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [63:0] seed_wdata,
	input  core_ctl_t   ctl,
	output core_sts_t   sts,
	input  logic [3:0]  rd_word,
	output word_t       rd_data
);

	core_state_t state_q;
	core_state_t state_nxt;
	logic [STEP_W-1:0] step_q;
	logic [63:0] seed_q;
	logic [63:0] ctr_q;
	blk_t        round_q;
	blk_t        ks_q;
	blk_t        init_w;
	blk_t        round_nxt;

	lanes_t     ax;
	lanes_t     ay;
	lanes_t     az;
	lanes_t     ax_nxt;
	lanes_t     az_nxt;
	logic [1:0] line;
	logic       diag;
	logic       last_step;

	assign init_w    = init_block(seed_q, ctr_q);
	assign line      = step_q[1:0];
	assign diag      = step_q[2];
	assign last_step = (step_q == STEP_W'(STEPS - 1));
	assign rd_data   = ks_q[rd_word];

	// odd lines work on c += d, b ^= c; even lines on a += b, d ^= a
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			ax[j] = round_q[lane_idx(j, diag, line[0] ? ROLE_C : ROLE_A)];
			ay[j] = round_q[lane_idx(j, diag, line[0] ? ROLE_D : ROLE_B)];
			az[j] = round_q[lane_idx(j, diag, line[0] ? ROLE_B : ROLE_D)];
		end
	end

	ccks_arx u_arx (
		.x     (ax),
		.y     (ay),
		.z     (az),
		.line  (line),
		.x_nxt (ax_nxt),
		.z_nxt (az_nxt)
	);

	always_comb begin
		round_nxt = round_q;
		for (int j = 0; j < LANES; j++) begin
			round_nxt[lane_idx(j, diag, line[0] ? ROLE_C : ROLE_A)] = ax_nxt[j];
			round_nxt[lane_idx(j, diag, line[0] ? ROLE_B : ROLE_D)] = az_nxt[j];
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			CORE_IDLE:  if (ctl.start) begin
				state_nxt = CORE_ROUND;
			end
			CORE_ROUND: if (last_step) begin
				state_nxt = CORE_FINAL;
			end
			CORE_FINAL: state_nxt = CORE_IDLE;
			default:    state_nxt = CORE_IDLE;
		endcase
	end

	always_comb begin
		sts.busy = (state_q != CORE_IDLE);
		sts.done = (state_q == CORE_FINAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_IDLE;
			step_q  <= '0;
			seed_q  <= '0;
			ctr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (seed_we) begin
				seed_q <= seed_wdata;
				ctr_q  <= '0;
			end else if (state_q == CORE_FINAL) begin
				ctr_q <= ctr_q + 64'd1;
			end
			if (state_q == CORE_ROUND) begin
				step_q <= last_step ? '0 : step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CORE_IDLE && ctl.start) begin
			round_q <= init_w;
		end else if (state_q == CORE_ROUND) begin
			round_q <= round_nxt;
		end
		if (state_q == CORE_FINAL) begin
			for (int i = 0; i < WORDS; i++) begin
				ks_q[i] <= round_q[i] + init_w[i];
			end
		end
	end

endmodule

>>> rtl/chacha20_keystream_byte_generator_top.sv
// top level of the chacha keystream byte generator: request handshake and byte server
// depends on ccks_pkg and ccks_core
//
// Each input item asks for 1 to 64 keystream bytes (0 gives no output, larger counts are
// clipped to 64); the block returns one output item per byte, in order, with tlast on the
// final byte of the run. Bytes come little-endian from a 64-byte ChaCha block keyed by the
// 64-bit seed, whose block counter steps once per block. Bytes stream at one per cycle
// after the item is taken, while the output side is ready; whenever the current block runs
// out, the shared four-lane ARX unit regenerates it through one load, 8 lines per double
// round times 10 and one feed-forward, and the stream waits. The next item is taken only
// once the run has been handed to the output register. Writing the seed restarts the
// counter and forces a fresh block on the next byte; write it only while no request is in
// flight.
module chacha20_keystream_byte_generator_top
	import ccks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// seed register write
	input  logic        seed_we,
	input  logic [63:0] seed_wdata,
	// request channel
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [6:0] byte_count, [7] zero
	// byte channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] random_byte
	output logic        m_axis_tlast
);

	top_state_t state_q;
	top_state_t state_nxt;

	logic [POS_W-1:0] rd_pos_q;   // next byte in the keystream block, 64 means used up
	logic [REQ_W-1:0] remain_q;   // bytes still owed for the current item
	logic [REQ_W-1:0] req_len;

	core_ctl_t core_ctl;
	core_sts_t core_sts;
	word_t     rd_data;
	logic [7:0] byte_sel;

	logic in_take;
	logic out_free;
	logic blk_empty;
	logic emit;

	assign req_len   = sat_count(s_axis_tdata[6:0]);
	assign in_take   = s_axis_tvalid && s_axis_tready;
	assign out_free  = !m_axis_tvalid || m_axis_tready;
	assign blk_empty = (rd_pos_q == POS_W'(BLOCK_BYTES));

	// low byte of the word first
	assign byte_sel = 8'(rd_data >> {rd_pos_q[1:0], 3'b000});

	ccks_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.ctl        (core_ctl),
		.sts        (core_sts),
		.rd_word    (rd_pos_q[5:2]),
		.rd_data    (rd_data)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			TOP_IDLE: if (in_take && req_len != '0) begin
				state_nxt = TOP_SERVE;
			end
			TOP_SERVE: begin
				if (blk_empty) begin
					state_nxt = TOP_GEN;
				end else if (out_free && remain_q == REQ_W'(1)) begin
					state_nxt = TOP_IDLE;
				end
			end
			TOP_GEN: if (core_sts.done) begin
				state_nxt = TOP_SERVE;
			end
			default: state_nxt = TOP_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready  = (state_q == TOP_IDLE);
		core_ctl.start = (state_q == TOP_SERVE) && blk_empty;
		emit           = (state_q == TOP_SERVE) && !blk_empty && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= TOP_IDLE;
			rd_pos_q      <= POS_W'(BLOCK_BYTES);
			remain_q      <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == TOP_IDLE && in_take) begin
				remain_q <= req_len;
			end else if (emit) begin
				remain_q <= remain_q - REQ_W'(1);
			end
			// a new seed forces a fresh block
			if (seed_we) begin
				rd_pos_q <= POS_W'(BLOCK_BYTES);
			end else if (state_q == TOP_GEN && core_sts.done) begin
				rd_pos_q <= '0;
			end else if (emit) begin
				rd_pos_q <= rd_pos_q + POS_W'(1);
			end
			if (emit) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// output item register
	always_ff @(posedge clk) begin
		if (emit) begin
			m_axis_tdata <= byte_sel;
			m_axis_tlast <= (remain_q == REQ_W'(1));
		end
	end

	// no request is taken while a block is being computed
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		core_sts.busy |-> !s_axis_tready)
		else $error("request taken while block in progress");

	// a block is only regenerated once the old one is used up
	a_start_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		core_ctl.start |-> rd_pos_q == POS_W'(BLOCK_BYTES))
		else $error("block regenerated before use");

	// a finished block restarts the read position
	a_done_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(core_sts.done && !seed_we) |=> rd_pos_q == '0)
		else $error("read position not rewound after block");

	// read position never runs past the block
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pos_q <= POS_W'(BLOCK_BYTES))
		else $error("read position out of range");

endmodule

>>> tb/tb_chacha20_keystream_byte_generator_top.sv
// self-checking bench for the chacha keystream byte generator: byte predictor, checker and stimulus
// depends on ccks_pkg (round count, request clip, block constants) and the top level of the block
import ccks_pkg::*;

// one expected output item: a keystream byte and its end-of-run mark
typedef struct {
	logic [7:0] value;
	logic       last;
} ks_byte_t;

// keeps its own copy of seed, block counter and current block and predicts every byte
class keystream_scoreboard;
	logic [63:0] seed;
	logic [63:0] block_ctr;
	logic [31:0] ks_word[16];
	logic [31:0] mix_word[16];
	int unsigned byte_pos;
	ks_byte_t    expected_bytes[$];
	int unsigned mismatches;

	function new();
		seed = '0;
		block_ctr = '0;
		byte_pos = BLOCK_BYTES;
		mismatches = 0;
	endfunction

	// a seed write restarts the counter and forces a fresh block
	function void load_seed(logic [63:0] value);
		seed = value;
		block_ctr = '0;
		byte_pos = BLOCK_BYTES;
	endfunction

	static function logic [31:0] rotl(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function void quarter_mix(int a, int b, int c, int d);
		mix_word[a] += mix_word[b];
		mix_word[d] = rotl(mix_word[d] ^ mix_word[a], 16);
		mix_word[c] += mix_word[d];
		mix_word[b] = rotl(mix_word[b] ^ mix_word[c], 12);
		mix_word[a] += mix_word[b];
		mix_word[d] = rotl(mix_word[d] ^ mix_word[a], 8);
		mix_word[c] += mix_word[d];
		mix_word[b] = rotl(mix_word[b] ^ mix_word[c], 7);
	endfunction

	function void next_block();
		logic [31:0] start_word[16];
		start_word[0]  = SIGMA0;
		start_word[1]  = SIGMA1;
		start_word[2]  = SIGMA2;
		start_word[3]  = SIGMA3;
		start_word[4]  = seed[31:0];
		start_word[5]  = seed[63:32];
		start_word[6]  = seed[31:0];
		start_word[7]  = seed[63:32];
		start_word[8]  = ~seed[31:0];
		start_word[9]  = ~seed[63:32];
		start_word[10] = seed[31:0];
		start_word[11] = seed[63:32];
		start_word[12] = block_ctr[31:0];
		start_word[13] = block_ctr[63:32];
		start_word[14] = '0;
		start_word[15] = '0;
		mix_word = start_word;
		for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
			quarter_mix(0, 4, 8, 12);
			quarter_mix(1, 5, 9, 13);
			quarter_mix(2, 6, 10, 14);
			quarter_mix(3, 7, 11, 15);
			quarter_mix(0, 5, 10, 15);
			quarter_mix(1, 6, 11, 12);
			quarter_mix(2, 7, 8, 13);
			quarter_mix(3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++) begin
			ks_word[i] = mix_word[i] + start_word[i];
		end
		block_ctr = block_ctr + 64'd1;
		byte_pos = 0;
	endfunction

	// accepted request: queue the bytes it must produce
	function void note_request(logic [6:0] cnt);
		int          n;
		ks_byte_t    entry;
		logic [31:0] w;
		n = int'(cnt);
		if (n > MAX_REQUEST) begin
			n = MAX_REQUEST;
		end
		for (int k = 0; k < n; k++) begin
			if (byte_pos >= BLOCK_BYTES) begin
				next_block();
			end
			w = ks_word[byte_pos >> 2];
			entry.value = w[8 * (byte_pos % 4) +: 8];
			entry.last = (k == n - 1);
			expected_bytes.push_back(entry);
			byte_pos++;
		end
	endfunction

	// accepted output item: compare with the oldest expectation
	function void check_byte(logic [7:0] value, logic last);
		ks_byte_t want;
		if (expected_bytes.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected byte, expected none, actual %h last %b",
				$time, value, last);
			return;
		end
		want = expected_bytes.pop_front();
		if (value !== want.value || last !== want.last) begin
			mismatches++;
			$display("%0t: byte mismatch, expected %h last %b, actual %h last %b",
				$time, want.value, want.last, value, last);
		end
	endfunction

	function int pending();
		return expected_bytes.size();
	endfunction
endclass

module tb_chacha20_keystream_byte_generator_top;

	localparam int RESET_CYCLES     = 12;
	localparam int CYCLE_LIMIT      = 1_000_000;
	// settle time covers a block regeneration, plus margin for the output register
	localparam int SETTLE_CYCLES    = 120;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int PHASES           = 6;
	localparam int PHASE_ITEMS      = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        seed_we = 1'b0;
	logic [63:0] seed_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [6:0] byte_count, [7] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [7:0] random_byte
	logic        m_axis_tlast;

	keystream_scoreboard sb = new();

	// no idling on either side once this is set
	bit quiet_tail = 1'b0;
	// asks the byte sink for one long hold-off
	bit sink_hold_req = 1'b0;
	int cycle_count = 0;

	chacha20_keystream_byte_generator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.seed_we       (seed_we),
		.seed_wdata    (seed_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 12-unit clock period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** chacha20_keystream_byte_generator_top: FAILED **");
			$finish;
		end
	end

	// byte sink: ready changes on the falling edge, random stall bursts of random length,
	// and one long hold-off on request so the block backs up into the request channel
	initial begin : byte_sink
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				m_axis_tready = 1'b0;
				repeat (SINK_HOLD_CYCLES) @(negedge clk);
				sink_hold_req = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
			m_axis_tready = 1'b1;
		end
	end

	// every accepted output item goes to the checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_byte(m_axis_tdata, m_axis_tlast);
		end
	end

	// offer one request from a falling edge until it is taken; returns on the next falling edge
	task automatic put_request(input logic [6:0] cnt);
		s_axis_tdata = {1'b0, cnt};
		s_axis_tvalid = 1'b1;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sb.note_request(cnt);
		@(negedge clk);
	endtask

	// random sender gap
	task automatic request_gap();
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// stop offering until every expected byte has come, then let the block settle,
	// since a zero-count item gives nothing to wait for
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// seed write, only while the block is idle
	task automatic write_seed(input logic [63:0] value);
		seed_wdata = value;
		seed_we = 1'b1;
		@(negedge clk);
		seed_we = 1'b0;
		sb.load_seed(value);
	endtask

	// mostly legal counts, some zero and some above the clip
	function automatic logic [6:0] random_count();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			return 7'd0;
		end else if (pick <= 2) begin
			return 7'($urandom_range(65, 127));
		end
		return 7'($urandom_range(1, 64));
	endfunction

	// directed counts under the reset seed: single byte, full block, zero, clipped,
	// all ones, block-boundary crossings
	logic [6:0] reset_seed_counts[12] = '{7'd1, 7'd64, 7'd0, 7'd65, 7'd127, 7'd2,
		7'd63, 7'd0, 7'd3, 7'd64, 7'd100, 7'd7};

	initial begin : stimulus
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset seed, counter at zero
		foreach (reset_seed_counts[i]) begin
			put_request(reset_seed_counts[i]);
			request_gap();
		end
		drain();

		// extreme seeds; second full block shows the counter step
		write_seed('1);
		put_request(7'd64);
		put_request(7'd64);
		put_request(7'd5);
		drain();
		write_seed(64'h0123_4567_89ab_cdef);
		put_request(7'd33);
		put_request(7'd30);
		drain();
		// seed write in the middle of a block restarts the stream
		write_seed('0);
		put_request(7'd10);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			quiet_tail = (phase == PHASES - 1);
			write_seed({$urandom, $urandom});
			if (phase == 2) begin
				// long receiver hold-off while requests keep coming back to back
				sink_hold_req = 1'b1;
				repeat (8) put_request(7'd64);
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				put_request(random_count());
				request_gap();
			end
			drain();
		end

		if (sb.pending() != 0) begin
			$display("%0t: %0d expected bytes never arrived", $time, sb.pending());
		end
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("** chacha20_keystream_byte_generator_top: PASSED **");
		end else begin
			$display("** chacha20_keystream_byte_generator_top: FAILED **");
		end
		$finish;
	end

endmodule
